@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros shared by the RTL files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every clock edge outside of reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Checked at every clock edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/bba_pkg.sv @@
// ----------------------------------------------------------------------------
// bba_pkg
// Types and constants of the first-fit block bitmap allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

    localparam int MAP_BITS  = 4096;
    localparam int WORD_BITS = 64;
    localparam int MAP_WORDS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;

    localparam int WORD_AW = $clog2(MAP_WORDS);
    localparam int BIT_AW  = $clog2(WORD_BITS);
    localparam int LIM_W   = WORD_AW + BIT_AW + 1;

    localparam int BLK_W  = 16;
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    typedef enum logic [0:0] {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_IGNORED = 2'd2
    } t_status;

    typedef enum logic [0:0] {
        REG_REGION_BASE = 1'b0,
        REG_DEVICE_SIZE = 1'b1
    } t_reg_idx;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FREE,
        S_DONE
    } t_state;

endpackage

@@ hw/rtl/bba_cmd_if.sv @@
// ----------------------------------------------------------------------------
// bba_cmd_if
// Command channel of the block allocator: one beat is one command.
// ----------------------------------------------------------------------------
interface bba_cmd_if;
    logic                     valid;
    logic                     ready;
    logic                     command;
    logic [bba_pkg::BLK_W-1:0] block_number;

    modport source (output valid, output command, output block_number, input ready);
    modport sink   (input valid, input command, input block_number, output ready);
endinterface

@@ hw/rtl/bba_res_if.sv @@
// ----------------------------------------------------------------------------
// bba_res_if
// Result channel of the block allocator: one beat per command.
// ----------------------------------------------------------------------------
interface bba_res_if;
    logic                     valid;
    logic                     ready;
    logic [1:0]               status;
    logic [bba_pkg::BLK_W-1:0] granted_block;

    modport source (output valid, output status, output granted_block, input ready);
    modport sink   (input valid, input status, input granted_block, output ready);
endinterface

@@ hw/rtl/bitmap_block_allocator.sv @@
// ----------------------------------------------------------------------------
// bitmap_block_allocator
// First-fit free-block bitmap with an APB register port.
// ----------------------------------------------------------------------------
// Commands arrive on i_cmd (allocate or free) and each produces exactly one
// result beat on o_res. The region base register (byte address 0) and the
// device size register (byte address 4) are written over the APB port; the
// user must write them only while no command is in flight, as the block
// itself does not enforce it. An allocate scans the bitmap RAM one word per
// cycle from word zero and stops at the first word with a clear bit inside
// the data region, after visiting 1 to 64 words. An allocate with no data
// blocks answers full without a RAM read. A free does a read-modify-write of
// one word; a free out of range answers without a RAM access.
// The single RAM read port sets the pace: one word per cycle.
// i_cmd.ready is high only while no command is being worked on. A finished
// result sits in the output register; the next command is taken while it
// waits, and its own result waits until the receiver takes the first one.
// Reset clears the sequencer state, the result valid flag and the APB
// registers and marks every bitmap word as unwritten, which reads as all
// blocks free; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bitmap_block_allocator (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    bba_cmd_if.sink                        i_cmd,
    bba_res_if.source                      o_res,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [bba_pkg::APB_AW-1:0]     paddr,
    input  logic [bba_pkg::APB_DW-1:0]     pwdata,
    output logic [bba_pkg::APB_DW-1:0]     prdata,
    output logic                           pready
);
    localparam int WB = bba_pkg::WORD_BITS;
    localparam int WA = bba_pkg::WORD_AW;
    localparam int BA = bba_pkg::BIT_AW;
    localparam int LW = bba_pkg::LIM_W;
    localparam int BW = bba_pkg::BLK_W;

    bba_pkg::t_state r_state, n_state;

    logic [BW-1:0]        r_ds, r_tb;
    logic [LW-1:0]        r_limit, n_limit;
    logic [WA-1:0]        r_word, n_word;
    logic [BA-1:0]        r_fbit, n_fbit;
    logic [1:0]           r_res_status, n_res_status;
    logic [BW-1:0]        r_res_grant, n_res_grant;
    logic [bba_pkg::MAP_WORDS-1:0] r_row_vld, n_row_vld;
    logic                 r_out_vld, n_out_vld;
    logic [1:0]           r_out_status, n_out_status;
    logic [BW-1:0]        r_out_grant, n_out_grant;

    logic                 ram_we, ram_re;
    logic [WA-1:0]        ram_waddr, ram_raddr;
    logic [WB-1:0]        ram_wdata, ram_rdata;

    logic                 cmd_acc;
    logic [BW:0]          diff;
    logic [LW-1:0]        limit_calc;
    logic [BW-1:0]        free_off;
    logic                 free_bad;
    logic [WB-1:0]        cur_word, avail, mask;
    logic [LW-1:0]        scan_base, next_base, rem;
    logic                 hit;
    logic [BA-1:0]        hit_bit;
    logic                 cfg_wr;

    bba_ram #(
        .WIDTH (WB),
        .DEPTH (bba_pkg::MAP_WORDS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ds <= '0;
            r_tb <= '0;
        end else if (cfg_wr) begin
            case (bba_pkg::t_reg_idx'(paddr[2]))
                bba_pkg::REG_REGION_BASE: r_ds <= pwdata[BW-1:0];
                bba_pkg::REG_DEVICE_SIZE: r_tb <= pwdata[BW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (bba_pkg::t_reg_idx'(paddr[2]))
            bba_pkg::REG_REGION_BASE: prdata = {{(bba_pkg::APB_DW-BW){1'b0}}, r_ds};
            bba_pkg::REG_DEVICE_SIZE: prdata = {{(bba_pkg::APB_DW-BW){1'b0}}, r_tb};
            default:                  prdata = '0;
        endcase
    end

    // ---------------- datapath helpers ----------------
    assign i_cmd.ready    = (r_state == bba_pkg::S_IDLE);
    assign cmd_acc        = i_cmd.valid && i_cmd.ready;
    assign o_res.valid    = r_out_vld;
    assign o_res.status   = r_out_status;
    assign o_res.granted_block = r_out_grant;

    // Data-block count, zero when the region ends before it starts, capped
    // at the map capacity.
    assign diff = {1'b0, r_tb} - {1'b0, r_ds};
    always_comb begin
        if (r_tb <= r_ds) begin
            limit_calc = '0;
        end else if (diff > (BW+1)'(bba_pkg::MAP_BITS)) begin
            limit_calc = LW'(bba_pkg::MAP_BITS);
        end else begin
            limit_calc = diff[LW-1:0];
        end
    end

    assign free_off = i_cmd.block_number - r_ds;
    assign free_bad = (i_cmd.block_number < r_ds) ||
                      ({1'b0, free_off} >= (BW+1)'(bba_pkg::MAP_BITS));

    // Words never written since reset read as all free.
    assign cur_word  = r_row_vld[r_word] ? ram_rdata : '0;
    assign scan_base = {1'b0, r_word, {BA{1'b0}}};
    assign next_base = {(WA+1)'({1'b0, r_word} + (WA+1)'(1)), {BA{1'b0}}};
    assign rem       = r_limit - scan_base;
    assign mask      = (rem >= LW'(WB)) ? {WB{1'b1}} : ~({WB{1'b1}} << rem[BA-1:0]);
    assign avail     = ~cur_word & mask;

    // Lowest set bit of the candidate vector.
    always_comb begin
        hit     = 1'b0;
        hit_bit = '0;
        for (int i = WB - 1; i >= 0; i--) begin
            if (avail[i]) begin
                hit     = 1'b1;
                hit_bit = BA'(i);
            end
        end
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= bba_pkg::S_IDLE;
            r_row_vld <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_row_vld <= n_row_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_limit      <= n_limit;
        r_word       <= n_word;
        r_fbit       <= n_fbit;
        r_res_status <= n_res_status;
        r_res_grant  <= n_res_grant;
        r_out_status <= n_out_status;
        r_out_grant  <= n_out_grant;
    end

    always_comb begin
        n_state      = r_state;
        n_limit      = r_limit;
        n_word       = r_word;
        n_fbit       = r_fbit;
        n_res_status = r_res_status;
        n_res_grant  = r_res_grant;
        n_row_vld    = r_row_vld;
        n_out_vld    = r_out_vld && !o_res.ready;
        n_out_status = r_out_status;
        n_out_grant  = r_out_grant;
        ram_we       = 1'b0;
        ram_waddr    = r_word;
        ram_wdata    = cur_word;
        ram_re       = 1'b0;
        ram_raddr    = '0;

        case (r_state)
            bba_pkg::S_IDLE: begin
                if (cmd_acc) begin
                    n_res_grant = '0;
                    if (i_cmd.command == bba_pkg::CMD_ALLOC) begin
                        n_limit = limit_calc;
                        n_word  = '0;
                        if (limit_calc == '0) begin
                            n_res_status = bba_pkg::ST_FULL;
                            n_state      = bba_pkg::S_DONE;
                        end else begin
                            ram_re    = 1'b1;
                            ram_raddr = '0;
                            n_state   = bba_pkg::S_SCAN;
                        end
                    end else if (free_bad) begin
                        n_res_status = bba_pkg::ST_IGNORED;
                        n_state      = bba_pkg::S_DONE;
                    end else begin
                        ram_re    = 1'b1;
                        ram_raddr = free_off[BA+WA-1:BA];
                        n_word    = free_off[BA+WA-1:BA];
                        n_fbit    = free_off[BA-1:0];
                        n_state   = bba_pkg::S_FREE;
                    end
                end
            end
            bba_pkg::S_SCAN: begin
                if (hit) begin
                    ram_we               = 1'b1;
                    ram_wdata            = cur_word | (WB'(1) << hit_bit);
                    n_row_vld[r_word]    = 1'b1;
                    n_res_status         = bba_pkg::ST_OK;
                    n_res_grant          = r_ds + BW'({r_word, hit_bit});
                    n_state              = bba_pkg::S_DONE;
                end else if (next_base >= r_limit) begin
                    n_res_status = bba_pkg::ST_FULL;
                    n_state      = bba_pkg::S_DONE;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = WA'(r_word + WA'(1));
                    n_word    = WA'(r_word + WA'(1));
                end
            end
            bba_pkg::S_FREE: begin
                ram_we            = 1'b1;
                ram_wdata         = cur_word & ~(WB'(1) << r_fbit);
                n_row_vld[r_word] = 1'b1;
                n_res_status      = bba_pkg::ST_OK;
                n_state           = bba_pkg::S_DONE;
            end
            bba_pkg::S_DONE: begin
                if (!r_out_vld || o_res.ready) begin
                    n_out_vld    = 1'b1;
                    n_out_status = r_res_status;
                    n_out_grant  = r_res_grant;
                    n_state      = bba_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bba_pkg::S_IDLE;
            end
        endcase
    end

    // ---------------- assertions ----------------
    `ASSERT_CLK(a_scan_in_region, i_clk, i_rst_n,
        (r_state == bba_pkg::S_SCAN) |-> (scan_base < r_limit),
        "scan visits a word beyond the data region")

    `ASSERT_CLK(a_busy_after_accept, i_clk, i_rst_n,
        cmd_acc |=> !i_cmd.ready,
        "command port ready right after a command was taken")

    `ASSERT_CLK(a_grant_only_ok, i_clk, i_rst_n,
        (o_res.valid && (o_res.status != bba_pkg::ST_OK)) |-> (o_res.granted_block == '0),
        "nonzero grant on a failed command")

    `ASSERT_ALWAYS(a_reset_clears, i_clk,
        (!i_rst_n) |=> (!o_res.valid && (r_state == bba_pkg::S_IDLE)),
        "reset did not clear the result and sequencer")

endmodule

@@ hw/rtl/bba_ram.sv @@
// ----------------------------------------------------------------------------
// bba_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module bba_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

@@ dv/bitmap_block_allocator_tb.sv @@
// ----------------------------------------------------------------------------
// bitmap_block_allocator_tb
// Self-checking bench for the first-fit block bitmap allocator. Commands go
// in through a queue-fed driver, results are checked against a local
// bitmap model, and the data region is reprogrammed over APB between phases.
// ----------------------------------------------------------------------------
module bitmap_block_allocator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int BLK_W    = bba_pkg::BLK_W;
    localparam int MAP_BITS = bba_pkg::MAP_BITS;
    localparam int APB_AW   = bba_pkg::APB_AW;
    localparam int APB_DW   = bba_pkg::APB_DW;

    localparam int CYCLE_LIMIT   = 400_000;
    localparam int SETTLE_CYCLES = 80;
    localparam int PHASE_ITEMS   = 75;
    localparam int RANDOM_PHASES = 10;

    typedef struct packed {
        bba_pkg::t_cmd    cmd;
        logic [BLK_W-1:0] blk;
    } t_block_cmd;

    typedef struct packed {
        bba_pkg::t_status status;
        logic [BLK_W-1:0] granted;
    } t_block_result;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [APB_AW-1:0] paddr   = '0;
    logic [APB_DW-1:0] pwdata  = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    bba_cmd_if cmd_bus();
    bba_res_if res_bus();

    bitmap_block_allocator i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_bus),
        .o_res   (res_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Model state: one bit per data block, set while the block is in use.
    bit               block_in_use [MAP_BITS];
    logic [BLK_W-1:0] cfg_region_base = '0;
    logic [BLK_W-1:0] cfg_device_size = '0;

    t_block_cmd    queued_commands [$];
    t_block_result pending_results [$];

    int  error_count   = 0;
    int  cycle_count   = 0;
    int  cmd_gap       = 0;
    int  res_stall     = 0;
    bit  cmd_fired     = 1'b0;
    bit  quiet         = 1'b0;
    int  grants        = 0;
    int  full_answers  = 0;
    int  ignored_frees = 0;
    int  done_frees    = 0;
    int  reg_writes    = 0;
    int  deepest_index = -1;

    initial begin
        cmd_bus.valid        = 1'b0;
        cmd_bus.command      = bba_pkg::CMD_ALLOC;
        cmd_bus.block_number = '0;
        res_bus.ready        = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Number of data blocks the current region allows, capped at the map size.
    function automatic int data_block_count();
        int span;
        span = 0;
        if (cfg_device_size > cfg_region_base)
            span = int'(cfg_device_size) - int'(cfg_region_base);
        if (span > MAP_BITS)
            span = MAP_BITS;
        return span;
    endfunction

    // Updates the bitmap for one accepted command and records its result.
    task automatic apply_block_command(input bba_pkg::t_cmd cmd,
                                       input logic [BLK_W-1:0] blk);
        t_block_result res;
        int            span;
        int            offset;
        bit            found;
        res.status  = bba_pkg::ST_OK;
        res.granted = '0;
        if (cmd == bba_pkg::CMD_ALLOC) begin
            span  = data_block_count();
            found = 1'b0;
            for (int i = 0; i < span && !found; i++) begin
                if (!block_in_use[i]) begin
                    block_in_use[i] = 1'b1;
                    res.granted     = BLK_W'(int'(cfg_region_base) + i);
                    found           = 1'b1;
                    if (i > deepest_index)
                        deepest_index = i;
                end
            end
            if (found) begin
                grants++;
            end else begin
                res.status = bba_pkg::ST_FULL;
                full_answers++;
            end
        end else begin
            offset = int'(blk) - int'(cfg_region_base);
            if (blk < cfg_region_base || offset >= MAP_BITS) begin
                res.status = bba_pkg::ST_IGNORED;
                ignored_frees++;
            end else begin
                block_in_use[offset] = 1'b0;
                done_frees++;
            end
        end
        pending_results.push_back(res);
    endtask

    // Command acceptance and result checking, both at the rising edge.
    always @(posedge i_clk) begin
        t_block_result want;
        cmd_fired = cmd_bus.valid && cmd_bus.ready;
        if (cmd_fired)
            apply_block_command(bba_pkg::t_cmd'(cmd_bus.command), cmd_bus.block_number);
        if (res_bus.valid && res_bus.ready) begin
            if (pending_results.size() == 0) begin
                $error("result beat with no command outstanding");
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (res_bus.status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, res_bus.status);
                    error_count++;
                end
                if (res_bus.granted_block !== want.granted) begin
                    $error("granted_block: expected %0d, actual %0d",
                           want.granted, res_bus.granted_block);
                    error_count++;
                end
            end
        end
    end

    // Command driver: holds a beat until it is taken, with random idle bursts.
    always @(negedge i_clk) begin
        t_block_cmd next;
        if (!i_rst_n) begin
            cmd_bus.valid <= 1'b0;
        end else if (!cmd_bus.valid || cmd_fired) begin
            if (cmd_gap > 0) begin
                cmd_gap--;
                cmd_bus.valid <= 1'b0;
            end else if (queued_commands.size() != 0) begin
                next = queued_commands.pop_front();
                cmd_bus.valid        <= 1'b1;
                cmd_bus.command      <= next.cmd;
                cmd_bus.block_number <= next.blk;
                if (!quiet && $urandom_range(0, 3) == 0)
                    cmd_gap = $urandom_range(1, 12);
            end else begin
                cmd_bus.valid <= 1'b0;
            end
        end
    end

    // Result receiver with random stall bursts.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            res_bus.ready <= 1'b0;
        end else if (res_stall > 0) begin
            res_stall--;
            res_bus.ready <= 1'b0;
        end else begin
            res_bus.ready <= 1'b1;
            if (!quiet && $urandom_range(0, 4) == 0)
                res_stall = $urandom_range(1, 12);
        end
    end

    task automatic queue_cmd(input bba_pkg::t_cmd cmd, input logic [BLK_W-1:0] blk);
        t_block_cmd item;
        item.cmd = cmd;
        item.blk = blk;
        queued_commands.push_back(item);
    endtask

    // Returns once every queued command has been taken and answered.
    task automatic wait_until_idle();
        do
            @(posedge i_clk);
        while (queued_commands.size() != 0 || cmd_bus.valid || pending_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // APB write with junk in the upper half, then a read back of the register.
    task automatic set_register(input bba_pkg::t_reg_idx idx, input logic [BLK_W-1:0] value);
        logic [APB_DW-1:0] got;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'($urandom()), value};
        @(negedge i_clk);
        penable <= 1'b1;
        do
            @(posedge i_clk);
        while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (idx == bba_pkg::REG_REGION_BASE)
            cfg_region_base = value;
        else
            cfg_device_size = value;
        reg_writes++;
        @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do
            @(posedge i_clk);
        while (!pready);
        got = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== {16'h0000, value}) begin
            $error("prdata: expected %0d, actual %0d", value, got);
            error_count++;
        end
    endtask

    task automatic set_region(input int start, input int total);
        wait_until_idle();
        set_register(bba_pkg::REG_REGION_BASE, BLK_W'(start));
        set_register(bba_pkg::REG_DEVICE_SIZE, BLK_W'(total));
    endtask

    // One phase of random commands: mostly allocates and frees of real data
    // blocks, with some random and boundary frees mixed in.
    task automatic random_commands(input int count);
        int span;
        int pick;
        for (int n = 0; n < count; n++) begin
            span = data_block_count();
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                queue_cmd(bba_pkg::CMD_ALLOC, BLK_W'($urandom()));
            end else if (pick < 80 && span > 0) begin
                queue_cmd(bba_pkg::CMD_FREE,
                          BLK_W'(int'(cfg_region_base) + $urandom_range(0, span - 1)));
            end else if (pick < 90) begin
                queue_cmd(bba_pkg::CMD_FREE, BLK_W'($urandom()));
            end else begin
                case ($urandom_range(0, 2))
                    0: begin
                        queue_cmd(bba_pkg::CMD_FREE, BLK_W'(int'(cfg_region_base) - 1));
                    end
                    1: begin
                        queue_cmd(bba_pkg::CMD_FREE,
                                  BLK_W'(int'(cfg_region_base) + MAP_BITS - 1));
                    end
                    default: begin
                        queue_cmd(bba_pkg::CMD_FREE,
                                  BLK_W'(int'(cfg_region_base) + MAP_BITS));
                    end
                endcase
            end
        end
    endtask

    initial begin
        int start;
        int total;
        do
            @(posedge i_clk);
        while (!i_rst_n);

        // Reset region is empty: allocates must come back full.
        queue_cmd(bba_pkg::CMD_ALLOC, 16'h0000);
        queue_cmd(bba_pkg::CMD_ALLOC, 16'hFFFF);

        // Region that ends before it starts, plus frees on both sides of it.
        set_region(100, 50);
        queue_cmd(bba_pkg::CMD_ALLOC, 16'h0000);
        queue_cmd(bba_pkg::CMD_FREE, 16'd99);
        queue_cmd(bba_pkg::CMD_FREE, 16'hFFFF);
        queue_cmd(bba_pkg::CMD_FREE, 16'd4100);

        // Four data blocks: fill, overflow, free twice, reuse, range edges.
        set_region(10, 14);
        repeat (5) queue_cmd(bba_pkg::CMD_ALLOC, 16'h0000);
        queue_cmd(bba_pkg::CMD_FREE, 16'd11);
        queue_cmd(bba_pkg::CMD_FREE, 16'd11);
        queue_cmd(bba_pkg::CMD_ALLOC, 16'h0000);
        queue_cmd(bba_pkg::CMD_FREE, 16'd9);
        queue_cmd(bba_pkg::CMD_FREE, 16'd4105);
        queue_cmd(bba_pkg::CMD_FREE, 16'd4106);

        // Region wider than the map.
        set_region(0, 65535);
        repeat (3) queue_cmd(bba_pkg::CMD_ALLOC, 16'h5A5A);
        queue_cmd(bba_pkg::CMD_FREE, 16'hFFFF);
        queue_cmd(bba_pkg::CMD_FREE, 16'h0000);

        // Both registers at their maximum.
        set_region(65535, 65535);
        queue_cmd(bba_pkg::CMD_ALLOC, 16'h0000);
        queue_cmd(bba_pkg::CMD_FREE, 16'hFFFF);
        queue_cmd(bba_pkg::CMD_FREE, 16'h0000);

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case ($urandom_range(0, 4))
                0: begin
                    start = $urandom_range(0, 65535);
                    total = start + $urandom_range(1, 300);
                end
                1: begin
                    start = $urandom_range(0, 2000);
                    total = $urandom_range(start + MAP_BITS, 65535);
                end
                2: begin
                    total = $urandom_range(0, 65534);
                    start = $urandom_range(total + 1, 65535);
                end
                3: begin
                    start = ($urandom_range(0, 1) == 0) ? 0 : 65535;
                    total = ($urandom_range(0, 1) == 0) ? 0 : 65535;
                end
                default: begin
                    start = $urandom_range(0, 60000);
                    total = start + $urandom_range(300, 2000);
                end
            endcase
            if (phase == 0) begin
                start = $urandom_range(0, 30);
                total = start + $urandom_range(40, 150);
            end
            if (total > 65535)
                total = 65535;
            set_region(start, total);
            if (phase == RANDOM_PHASES - 1)
                quiet = 1'b1;
            random_commands(PHASE_ITEMS);
        end

        wait_until_idle();
        $display("Covered %0d grants, %0d full answers, %0d frees, %0d ignored frees.",
                 grants, full_answers, done_frees, ignored_frees);
        $display("Deepest bit granted %0d, %0d register writes, %0d cycles.",
                 deepest_index, reg_writes, cycle_count);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
